@@ design/ipsc_pkg.sv @@
`timescale 1ns / 1ps
package ipsc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ACC_WIDTH = 48;

    // product terms are saturated to a magnitude of 2^61
    localparam int LIM_BIT = 61;
    localparam int MAG_W   = 64;
    localparam int PROD_W  = 2 * MAG_W;
    localparam logic [MAG_W-1:0] TERM_LIM = MAG_W'(1) << LIM_BIT;

    // quotient bits of the derivative division (numerator magnitude shifted up)
    localparam int QUO_W     = LIM_BIT + 1 + FRAC_BITS;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int MUL_STEPS = 4;

    // register indexes
    localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd3;
    localparam logic [2:0] REG_TARGET_SPEED  = 3'd4;
    localparam logic [2:0] REG_OUT_MIN       = 3'd5;
    localparam logic [2:0] REG_OUT_MAX       = 3'd6;

    // reset values
    localparam longint SCALE   = longint'(1) << FRAC_BITS;
    localparam longint KP_VAL  = 15 * SCALE;
    localparam longint KI_RAW  = 300 * SCALE;
    localparam longint KI_VAL  = (KI_RAW > 64'sd2147483647) ? 64'sd2147483647 : KI_RAW;
    localparam longint TS_VAL  = (SCALE + 50) / 100;
    localparam longint LIM_VAL = 100 * SCALE;

    localparam logic [31:0] PROP_GAIN_RST     = 32'(KP_VAL);
    localparam logic [31:0] INTEGRAL_GAIN_RST = 32'(KI_VAL);
    localparam logic [30:0] SAMPLE_PERIOD_RST = 31'(TS_VAL);
    localparam logic [31:0] OUT_MIN_RST       = 32'(-LIM_VAL);
    localparam logic [31:0] OUT_MAX_RST       = 32'(LIM_VAL);

    // multiply operations, in the order they run
    localparam logic [2:0] MOP_P  = 3'd0;  // kp * (e - e_prev)
    localparam logic [2:0] MOP_KT = 3'd1;  // ki * ts
    localparam logic [2:0] MOP_IT = 3'd2;  // (ki*ts) * e
    localparam logic [2:0] MOP_KK = 3'd3;  // kp * kp
    localparam logic [2:0] MOP_KD = 3'd4;  // (kp*kp) * kd
    localparam logic [2:0] MOP_ND = 3'd5;  // kd' * d2y

    typedef struct packed {
        logic       load;
        logic       mul_start;
        logic       mul_pp_en;
        logic [1:0] mul_pp_idx;
        logic       mul_acc_en;
        logic [1:0] mul_acc_idx;
        logic       mul_store;
        logic [2:0] mop;
        logic       div_start;
        logic       div_step;
        logic       div_store;
        logic       sum_en;
        logic       acc_en;
        logic       out_load;
    } cmd_t;

endpackage

@@ design/incremental_pid_speed_control_unit.sv @@
// sequence: six multiplies, then a 78-step restoring division at 16 fraction bits,
//   then the sum, accumulate and output states
// flow: the next input is taken once the previous item reaches the output register,
//   which holds its result until transfer
// reset: synchronous active-low aresetn restores register defaults and clears
//   the speed history, previous error and accumulator
`timescale 1ns / 1ps
module incremental_pid_speed_control_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] measured_speed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] drive_value, [63:32] loop_error
    output logic        m_tuser,    // [0] clipped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    ipsc_pkg::cmd_t     cmd;
    logic signed [31:0] drive_value;
    logic signed [31:0] loop_error;
    logic               clipped;

    assign cfg_ready = 1'b1;

    ipsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ipsc_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg_we         (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .measured_speed (s_tdata),
        .drive_value    (drive_value),
        .loop_error     (loop_error),
        .clipped        (clipped)
    );

    assign m_tdata = {loop_error, drive_value};
    assign m_tuser = clipped;

endmodule

@@ design/ipsc_mul.sv @@
`timescale 1ns / 1ps
module ipsc_mul (
    input  logic                               aclk,
    input  logic                               start,
    input  logic signed [ipsc_pkg::MAG_W-1:0]  op_a,
    input  logic signed [ipsc_pkg::MAG_W-1:0]  op_b,
    input  logic                               pp_en,
    input  logic [1:0]                         pp_idx,
    input  logic                               acc_en,
    input  logic [1:0]                         acc_idx,
    output logic signed [ipsc_pkg::MAG_W-1:0]  result
);

    logic [ipsc_pkg::MAG_W-1:0]  ma_reg, mb_reg;
    logic                        neg_reg;
    logic [63:0]                 pp_reg;
    logic [ipsc_pkg::PROD_W-1:0] prod_reg;

    logic [31:0]                 a_half, b_half;
    logic [ipsc_pkg::PROD_W-1:0] pp_shifted;
    logic [ipsc_pkg::PROD_W-ipsc_pkg::FRAC_BITS-1:0] rounded;
    logic [ipsc_pkg::MAG_W-1:0]  mag;

    always_comb begin
        a_half     = pp_idx[0] ? ma_reg[63:32] : ma_reg[31:0];
        b_half     = pp_idx[1] ? mb_reg[63:32] : mb_reg[31:0];
        pp_shifted = ipsc_pkg::PROD_W'(pp_reg)
                     << (32 * (int'(acc_idx[0]) + int'(acc_idx[1])));
        // rounding half was preloaded into the product
        rounded    = prod_reg[ipsc_pkg::PROD_W-1:ipsc_pkg::FRAC_BITS];
        mag        = (rounded > (ipsc_pkg::PROD_W-ipsc_pkg::FRAC_BITS)'(ipsc_pkg::TERM_LIM))
                     ? ipsc_pkg::TERM_LIM : rounded[ipsc_pkg::MAG_W-1:0];
        result     = neg_reg ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ma_reg   <= op_a[ipsc_pkg::MAG_W-1] ? -op_a : op_a;
            mb_reg   <= op_b[ipsc_pkg::MAG_W-1] ? -op_b : op_b;
            neg_reg  <= op_a[ipsc_pkg::MAG_W-1] ^ op_b[ipsc_pkg::MAG_W-1];
            prod_reg <= ipsc_pkg::PROD_W'(1) << (ipsc_pkg::FRAC_BITS - 1);
        end else if (acc_en) begin
            prod_reg <= prod_reg + pp_shifted;
        end
        if (pp_en) begin
            pp_reg <= a_half * b_half;
        end
    end

endmodule

@@ design/ipsc_div.sv @@
`timescale 1ns / 1ps
module ipsc_div (
    input  logic                               aclk,
    input  logic                               start,
    input  logic                               step,
    input  logic signed [ipsc_pkg::MAG_W-1:0]  num,
    input  logic [30:0]                        ts,
    output logic signed [ipsc_pkg::MAG_W-1:0]  result
);

    logic [ipsc_pkg::QUO_W-1:0] dq_reg;
    logic [30:0]                rem_reg;
    logic [30:0]                ts_reg;
    logic                       neg_reg;

    logic [ipsc_pkg::MAG_W-1:0] num_mag;
    logic [31:0]                trial;
    logic                       fits;
    logic                       round_up;
    logic [ipsc_pkg::QUO_W:0]   q_round;
    logic [ipsc_pkg::MAG_W-1:0] mag;

    always_comb begin
        num_mag  = num[ipsc_pkg::MAG_W-1] ? -num : num;
        trial    = {rem_reg, dq_reg[ipsc_pkg::QUO_W-1]};
        fits     = trial >= {1'b0, ts_reg};
        round_up = {rem_reg, 1'b0} >= {1'b0, ts_reg};
        q_round  = {1'b0, dq_reg} + (ipsc_pkg::QUO_W+1)'(round_up);
        mag      = (q_round > (ipsc_pkg::QUO_W+1)'(ipsc_pkg::TERM_LIM))
                   ? ipsc_pkg::TERM_LIM : q_round[ipsc_pkg::MAG_W-1:0];
        result   = neg_reg ? -$signed(mag) : $signed(mag);
    end

    // restoring division, one quotient bit per cycle while step is asserted
    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= {num_mag[ipsc_pkg::LIM_BIT:0], {ipsc_pkg::FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            ts_reg  <= (ts == '0) ? 31'd1 : ts;
            neg_reg <= num[ipsc_pkg::MAG_W-1];
        end else if (step) begin
            dq_reg  <= {dq_reg[ipsc_pkg::QUO_W-2:0], fits};
            rem_reg <= fits ? 31'(trial - {1'b0, ts_reg}) : trial[30:0];
        end
    end

endmodule

@@ design/ipsc_dp.sv @@
`timescale 1ns / 1ps
module ipsc_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ipsc_pkg::cmd_t        cmd,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic signed [31:0]    measured_speed,
    output logic signed [31:0]    drive_value,
    output logic signed [31:0]    loop_error,
    output logic                  clipped
);

    localparam int AW = ipsc_pkg::ACC_WIDTH;
    localparam int MW = ipsc_pkg::MAG_W;

    logic signed [31:0] prop_gain_reg, integral_gain_reg, deriv_gain_reg;
    logic signed [31:0] target_speed_reg, out_min_reg, out_max_reg;
    logic [30:0]        sample_period_reg;

    logic signed [31:0] speed_prev_reg, speed_prev2_reg, error_prev_reg;
    logic signed [AW-1:0] acc_reg;

    logic signed [31:0] y_reg, e_reg;
    logic signed [32:0] de_reg;
    logic signed [34:0] d2y_reg;
    logic signed [MW-1:0] p_reg, t_reg, k_reg;
    logic signed [31:0] dc_reg;

    logic signed [31:0] drive_reg, error_out_reg;
    logic               clip_reg;

    logic signed [31:0] e_next;
    logic signed [MW-1:0] op_a, op_b, mul_res, div_res, d_sum;
    logic signed [31:0] dc_next;
    logic signed [AW:0] acc_sum;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] lim_hi, lim_lo;

    always_comb begin
        e_next = target_speed_reg - measured_speed;

        unique case (cmd.mop)
            ipsc_pkg::MOP_P: begin
                op_a = MW'(prop_gain_reg);
                op_b = MW'(de_reg);
            end
            ipsc_pkg::MOP_KT: begin
                op_a = MW'(integral_gain_reg);
                op_b = $signed(MW'(sample_period_reg));
            end
            ipsc_pkg::MOP_IT: begin
                op_a = t_reg;
                op_b = MW'(e_reg);
            end
            ipsc_pkg::MOP_KK: begin
                op_a = MW'(prop_gain_reg);
                op_b = MW'(prop_gain_reg);
            end
            ipsc_pkg::MOP_KD: begin
                op_a = k_reg;
                op_b = MW'(deriv_gain_reg);
            end
            default: begin
                op_a = k_reg;
                op_b = MW'(d2y_reg);
            end
        endcase

        d_sum = p_reg + t_reg - k_reg;
        // upper limit is tested first
        if (d_sum > MW'(out_max_reg)) begin
            dc_next = out_max_reg;
        end else if (d_sum < MW'(out_min_reg)) begin
            dc_next = out_min_reg;
        end else begin
            dc_next = d_sum[31:0];
        end

        acc_sum = (AW+1)'(acc_reg) + (AW+1)'(dc_reg);
        if (acc_sum[AW] != acc_sum[AW-1]) begin
            acc_next = acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            acc_next = acc_sum[AW-1:0];
        end

        lim_hi = AW'(out_max_reg);
        lim_lo = AW'(out_min_reg);
    end

    ipsc_mul u_mul (
        .aclk    (aclk),
        .start   (cmd.mul_start),
        .op_a    (op_a),
        .op_b    (op_b),
        .pp_en   (cmd.mul_pp_en),
        .pp_idx  (cmd.mul_pp_idx),
        .acc_en  (cmd.mul_acc_en),
        .acc_idx (cmd.mul_acc_idx),
        .result  (mul_res)
    );

    ipsc_div u_div (
        .aclk   (aclk),
        .start  (cmd.div_start),
        .step   (cmd.div_step),
        .num    (k_reg),
        .ts     (sample_period_reg),
        .result (div_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= ipsc_pkg::PROP_GAIN_RST;
            integral_gain_reg <= ipsc_pkg::INTEGRAL_GAIN_RST;
            deriv_gain_reg    <= '0;
            sample_period_reg <= ipsc_pkg::SAMPLE_PERIOD_RST;
            target_speed_reg  <= '0;
            out_min_reg       <= ipsc_pkg::OUT_MIN_RST;
            out_max_reg       <= ipsc_pkg::OUT_MAX_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ipsc_pkg::REG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                ipsc_pkg::REG_INTEGRAL_GAIN: integral_gain_reg <= cfg_data;
                ipsc_pkg::REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data;
                ipsc_pkg::REG_SAMPLE_PERIOD: sample_period_reg <= cfg_data[30:0];
                ipsc_pkg::REG_TARGET_SPEED:  target_speed_reg  <= cfg_data;
                ipsc_pkg::REG_OUT_MIN:       out_min_reg       <= cfg_data;
                ipsc_pkg::REG_OUT_MAX:       out_max_reg       <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_prev_reg  <= '0;
            speed_prev2_reg <= '0;
            error_prev_reg  <= '0;
            acc_reg         <= '0;
        end else begin
            if (cmd.acc_en) begin
                acc_reg <= acc_next;
            end
            if (cmd.out_load) begin
                speed_prev2_reg <= speed_prev_reg;
                speed_prev_reg  <= y_reg;
                error_prev_reg  <= e_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            y_reg   <= measured_speed;
            e_reg   <= e_next;
            de_reg  <= 33'(e_next) - 33'(error_prev_reg);
            d2y_reg <= 35'(measured_speed) - (35'(speed_prev_reg) <<< 1)
                       + 35'(speed_prev2_reg);
        end
        if (cmd.mul_store) begin
            unique case (cmd.mop)
                ipsc_pkg::MOP_P:                  p_reg <= mul_res;
                ipsc_pkg::MOP_KT, ipsc_pkg::MOP_IT: t_reg <= mul_res;
                default:                          k_reg <= mul_res;
            endcase
        end else if (cmd.div_store) begin
            k_reg <= div_res;
        end
        if (cmd.sum_en) begin
            dc_reg <= dc_next;
        end
        if (cmd.out_load) begin
            error_out_reg <= e_reg;
            if (acc_reg > lim_hi) begin
                drive_reg <= out_max_reg;
                clip_reg  <= 1'b1;
            end else if (acc_reg < lim_lo) begin
                drive_reg <= out_min_reg;
                clip_reg  <= 1'b1;
            end else begin
                drive_reg <= acc_reg[31:0];
                clip_reg  <= 1'b0;
            end
        end
    end

    assign drive_value = drive_reg;
    assign loop_error  = error_out_reg;
    assign clipped     = clip_reg;

endmodule

@@ design/ipsc_ctrl.sv @@
`timescale 1ns / 1ps
module ipsc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output ipsc_pkg::cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MLOAD = 4'd1;
    localparam logic [3:0] ST_MSTEP = 4'd2;
    localparam logic [3:0] ST_MRES  = 4'd3;
    localparam logic [3:0] ST_DLOAD = 4'd4;
    localparam logic [3:0] ST_DSTEP = 4'd5;
    localparam logic [3:0] ST_DRES  = 4'd6;
    localparam logic [3:0] ST_SUM   = 4'd7;
    localparam logic [3:0] ST_ACC   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    localparam int CW = ipsc_pkg::CNT_W;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    mop_reg, mop_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        mop_next   = mop_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mop    = mop_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    mop_next   = ipsc_pkg::MOP_P;
                    state_next = ST_MLOAD;
                end
            end
            ST_MLOAD: begin
                cmd.mul_start = 1'b1;
                cnt_next      = '0;
                state_next    = ST_MSTEP;
            end
            ST_MSTEP: begin
                // partial products are registered in the cycle before their accumulation
                cmd.mul_pp_en   = cnt_reg < CW'(ipsc_pkg::MUL_STEPS);
                cmd.mul_pp_idx  = cnt_reg[1:0];
                cmd.mul_acc_en  = cnt_reg != '0;
                cmd.mul_acc_idx = 2'(cnt_reg - CW'(1));
                if (cnt_reg == CW'(ipsc_pkg::MUL_STEPS)) begin
                    state_next = ST_MRES;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_MRES: begin
                cmd.mul_store = 1'b1;
                if (mop_reg == ipsc_pkg::MOP_ND) begin
                    state_next = ST_DLOAD;
                end else begin
                    mop_next   = mop_reg + 3'd1;
                    state_next = ST_MLOAD;
                end
            end
            ST_DLOAD: begin
                cmd.div_start = 1'b1;
                cnt_next      = '0;
                state_next    = ST_DSTEP;
            end
            ST_DSTEP: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CW'(ipsc_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_DRES;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_DRES: begin
                cmd.div_store = 1'b1;
                state_next    = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_en = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mop_reg       <= ipsc_pkg::MOP_P;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mop_reg       <= mop_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_load_starts_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_MLOAD && mop_reg == ipsc_pkg::MOP_P)
        else $error("load not followed by first multiply");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !out_valid_reg || m_tready)
        else $error("result overwritten before transfer");
    a_div_after_last_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> $past(cmd.mul_store) && $past(mop_reg) == ipsc_pkg::MOP_ND)
        else $error("division started before the numerator was ready");
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !cmd.mul_pp_en && !cmd.div_step && !cmd.acc_en)
        else $error("datapath active while idle");
`endif

endmodule
